/* design/pll_pkg.sv */
// ----------------------------------------------------------------------------
// pll_pkg
// shared types and codes for the positional list engine
// ----------------------------------------------------------------------------
package pll_pkg;

	localparam int DATA_W = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	localparam logic [DATA_W-1:0] NO_VALUE = '1;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// command broadcast to every cell in the row
	typedef struct packed {
		logic ins;   // accepted insert that changes the list
		logic del;   // accepted delete that changes the list
		logic adv;   // pipeline moves this cycle
	} cmd_t;

endpackage

/* design/pll_cell.sv */
// ----------------------------------------------------------------------------
// pll_cell
// one list slot: holds an element, shifts to or from its neighbors and
// presents its element on a tap register when it is the one being deleted
// ----------------------------------------------------------------------------
module pll_cell #(
	parameter int IDX = 0,
	parameter int PW  = 7
) (
	input  logic                        clk,
	input  pll_pkg::cmd_t               cmd,
	input  logic [PW-1:0]               pos,
	input  logic [pll_pkg::DATA_W-1:0]  new_data,
	input  logic [pll_pkg::DATA_W-1:0]  left_data,
	input  logic [pll_pkg::DATA_W-1:0]  right_data,
	output logic [pll_pkg::DATA_W-1:0]  data,
	output logic [pll_pkg::DATA_W-1:0]  tap
);
	import pll_pkg::*;

	localparam logic [PW-1:0] MY_IDX  = PW'(IDX);
	localparam logic [PW-1:0] MY_IDX1 = PW'(IDX + 1);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] tap_s1;

	always_ff @(posedge clk) begin
		if (cmd.ins && (MY_IDX == pos)) begin
			data_q <= new_data;
		end else if (cmd.ins && (MY_IDX > pos)) begin
			data_q <= left_data;
		end else if (cmd.del && (MY_IDX1 >= pos)) begin
			data_q <= right_data;
		end
	end

	// delete position is 1-based, so this cell is hit when idx+1 == pos
	always_ff @(posedge clk) begin
		if (cmd.adv) begin
			tap_s1 <= (cmd.del && (MY_IDX1 == pos)) ? data_q : '0;
		end
	end

	assign data = data_q;
	assign tap  = tap_s1;

endmodule

/* design/positional_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// ordered list of signed 32-bit values with insert and delete by position
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (low bit up)
// s_axis    in   op, position, value
// m_axis    out  status, removed_value, list_length
//
// one item per cycle while the output is not stalled; each result is registered
// in the s1, s2 and output registers. the list sits in a row of cells; those at
// and past the position shift in the accept cycle, so the next item sees the updated
// list; the removed value goes through a two-level registered or tree over the cell taps.
// reset empties the list at once; cell contents are not cleared.
// a stalled output holds the whole pipeline and s_axis_tready with it.
// ----------------------------------------------------------------------------
module positional_list_insert_delete #(
	parameter  int CAPACITY = 64,
	localparam int PW       = $clog2(CAPACITY + 1),
	localparam int IN_W     = ((1 + PW + pll_pkg::DATA_W + 7) / 8) * 8,
	localparam int OUT_W    = ((2 + pll_pkg::DATA_W + PW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // op, position, value
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata    // status, removed_value, list_length
);
	import pll_pkg::*;

	localparam int GRP = 8;
	localparam int NG  = (CAPACITY + GRP - 1) / GRP;
	localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

	logic              adv;
	logic              accept;
	logic              in_op;
	logic [PW-1:0]     in_pos;
	logic [DATA_W-1:0] in_value;

	logic [PW-1:0]     count_q;
	logic              ins_ok;
	logic              del_ok;
	status_t           status_d;
	logic [PW-1:0]     count_d;
	cmd_t              cmd;

	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] cell_tap  [CAPACITY];

	logic              valid_s1;
	status_t           status_s1;
	logic              del_s1;
	logic [PW-1:0]     len_s1;

	logic              valid_s2;
	status_t           status_s2;
	logic              del_s2;
	logic [PW-1:0]     len_s2;
	logic [DATA_W-1:0] grp_s2 [NG];
	logic [DATA_W-1:0] grp_d  [NG];
	logic [DATA_W-1:0] tree_or;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [DATA_W-1:0] out_removed_q;
	logic [PW-1:0]     out_len_q;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;

	assign in_op    = s_axis_tdata[0];
	assign in_pos   = s_axis_tdata[PW:1];
	assign in_value = s_axis_tdata[PW+DATA_W:PW+1];

	// position is checked before fullness
	always_comb begin
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		status_d = ST_DONE;
		count_d  = count_q;
		if (in_op == OP_INSERT) begin
			if (in_pos > count_q) begin
				status_d = ST_BAD_POS;
			end else if (count_q >= CAP_P) begin
				status_d = ST_FULL;
			end else begin
				ins_ok  = 1'b1;
				count_d = count_q + 1'b1;
			end
		end else begin
			if ((in_pos == '0) || (in_pos > count_q)) begin
				status_d = ST_BAD_POS;
			end else begin
				del_ok  = 1'b1;
				count_d = count_q - 1'b1;
			end
		end
	end

	assign cmd.ins = accept && ins_ok;
	assign cmd.del = accept && del_ok;
	assign cmd.adv = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = in_value;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		pll_cell #(
			.IDX (i),
			.PW  (PW)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.pos        (in_pos),
			.new_data   (in_value),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.tap        (cell_tap[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s1 <= status_d;
			del_s1    <= del_ok;
			len_s1    <= count_d;
		end
	end

	// first tree level: one or per group of cells
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < CAPACITY) begin
					grp_d[g] = grp_d[g] | cell_tap[g*GRP+j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= status_s1;
			del_s2    <= del_s1;
			len_s2    <= len_s1;
			grp_s2    <= grp_d;
		end
	end

	always_comb begin
		tree_or = '0;
		for (int g = 0; g < NG; g++) begin
			tree_or = tree_or | grp_s2[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_status_q  <= status_s2;
			out_removed_q <= del_s2 ? tree_or : NO_VALUE;
			out_len_q     <= len_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({out_len_q, out_removed_q, out_status_q});

endmodule

/* design/pll_check.sv */
// ----------------------------------------------------------------------------
// pll_check
// port-level checks for the positional list engine, bound to the top level
// ----------------------------------------------------------------------------
module pll_check #(
	parameter  int CAPACITY = 64,
	localparam int PW       = $clog2(CAPACITY + 1),
	localparam int OUT_W    = ((2 + pll_pkg::DATA_W + PW + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata    // status, removed_value, list_length
);
	import pll_pkg::*;

	logic [1:0]        out_status;
	logic [DATA_W-1:0] out_removed;
	logic [PW-1:0]     out_len;

	assign out_status  = m_axis_tdata[1:0];
	assign out_removed = m_axis_tdata[DATA_W+1:2];
	assign out_len     = m_axis_tdata[DATA_W+PW+1:DATA_W+2];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_len <= PW'(CAPACITY))
		else $error("list length above capacity");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_status == ST_FULL) |-> out_len == PW'(CAPACITY))
		else $error("full status on a list that is not full");

	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ((out_status == ST_FULL) || (out_status == ST_BAD_POS))
		|-> out_removed == NO_VALUE)
		else $error("failed item reports a removed value");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_status == ST_DONE) || (out_status == ST_BAD_POS)
		|| (out_status == ST_FULL))
		else $error("unknown status code");

endmodule

bind positional_list_insert_delete pll_check #(.CAPACITY(CAPACITY)) u_pll_check (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the positional list engine: a scoreboard keeps its
// own copy of the list, predicts status, removed value and length for every
// accepted item, and checks each result in order under random source gaps
// and sink stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	import pll_pkg::*;

	localparam int CAPACITY = 64;
	localparam int PW       = 7;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 48;
	localparam int LIMIT    = 400000;

	typedef struct {
		status_t           status;
		logic [DATA_W-1:0] removed;
		logic [PW-1:0]     length;
	} list_result_t;

	class list_scoreboard;
		logic [DATA_W-1:0] cells[CAPACITY];
		int                count;
		list_result_t      pending[$];
		int                errors;

		function new();
			count  = 0;
			errors = 0;
		endfunction

		// apply one accepted item to the shadow list and queue its result
		function void note_item(logic op, logic [PW-1:0] pos, logic [DATA_W-1:0] val);
			list_result_t res;
			res.status  = ST_DONE;
			res.removed = NO_VALUE;
			if (op == OP_INSERT) begin
				if (pos > count) begin
					res.status = ST_BAD_POS;
				end else if (count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (int i = count; i > pos; i--)
						cells[i] = cells[i-1];
					cells[pos] = val;
					count++;
				end
			end else begin
				if (pos == 0 || pos > count) begin
					res.status = ST_BAD_POS;
				end else begin
					res.removed = cells[pos-1];
					for (int i = pos - 1; i + 1 < count; i++)
						cells[i] = cells[i+1];
					count--;
				end
			end
			res.length = count[PW-1:0];
			pending.push_back(res);
		endfunction

		function void check_result(logic [OUT_W-1:0] data);
			list_result_t exp;
			if (pending.size() == 0) begin
				$error("result with no item outstanding: %h", data);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (data[1:0] !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, data[1:0]);
				errors++;
			end
			if (data[33:2] !== exp.removed) begin
				$error("removed_value: expected %0d, got %0d",
					$signed(exp.removed), $signed(data[33:2]));
				errors++;
			end
			if (data[40:34] !== exp.length) begin
				$error("list_length: expected %0d, got %0d", exp.length, data[40:34]);
				errors++;
			end
			if (data[OUT_W-1:41] !== '0) begin
				$error("pad: expected 0, got %h", data[OUT_W-1:41]);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;   // op, position, value
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;        // status, removed_value, list_length

	list_scoreboard sb;
	bit             gaps_on;
	int             burst_left;
	int             cycles;
	int             sink_mode;
	int             sink_left;

	positional_list_insert_delete #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// sink: segments of always ready, light stalls and long stalls
	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_mode <= $urandom_range(0, 2);
			sink_left <= $urandom_range(20, 150);
		end else begin
			sink_left <= sink_left - 1;
		end
		case (sink_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) != 0);
			default: m_axis_tready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_item(logic op, logic [PW-1:0] pos, logic [DATA_W-1:0] val);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {val, pos, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_item(op, pos, val);
		if (gaps_on) begin
			if (burst_left == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 20);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return NO_VALUE;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	// mostly in-range positions, with some anywhere in the field
	task automatic send_random(int ins_pct);
		logic          op;
		logic [PW-1:0] pos;
		op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE;
		if ($urandom_range(0, 9) == 0)
			pos = PW'($urandom_range(0, 127));
		else if (op == OP_INSERT)
			pos = PW'($urandom_range(0, sb.count));
		else
			pos = (sb.count == 0) ? '0 : PW'($urandom_range(1, sb.count));
		send_item(op, pos, pick_value());
	endtask

	initial begin
		int ins_pct[6];
		sb         = new();
		burst_left = 0;
		gaps_on    = 1'b1;
		ins_pct    = '{90, 20, 85, 50, 10, 60};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, bad positions, corner values, delete of a stored -1
		send_item(OP_DELETE, 7'd0, $urandom);
		send_item(OP_DELETE, 7'd1, $urandom);
		send_item(OP_INSERT, 7'd1, $urandom);
		send_item(OP_INSERT, 7'd127, 32'h1234_5678);
		send_item(OP_INSERT, 7'd0, 32'h7FFF_FFFF);
		send_item(OP_INSERT, 7'd0, 32'h8000_0000);
		send_item(OP_INSERT, 7'd2, NO_VALUE);
		send_item(OP_INSERT, 7'd1, 32'h0);
		send_item(OP_INSERT, 7'd5, 32'h5555_AAAA);
		send_item(OP_DELETE, 7'd0, $urandom);
		send_item(OP_DELETE, 7'd5, $urandom);
		send_item(OP_DELETE, 7'd4, $urandom);
		send_item(OP_DELETE, 7'd1, $urandom);
		send_item(OP_DELETE, 7'd127, $urandom);
		send_item(OP_INSERT, 7'd2, 32'hAAAA_5555);
		send_item(OP_DELETE, 7'd2, $urandom);
		send_item(OP_DELETE, 7'd1, $urandom);
		send_item(OP_DELETE, 7'd1, $urandom);
		send_item(OP_DELETE, 7'd1, $urandom);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			gaps_on = (ph != 2);
			for (int n = 0; n < 80; n++)
				send_random(ins_pct[ph]);
			// top the list off once, then hit it while full
			if (ph == 0) begin
				while (sb.count < CAPACITY)
					send_item(OP_INSERT, PW'($urandom_range(0, sb.count)), pick_value());
				send_item(OP_INSERT, 7'd0, $urandom);
				send_item(OP_INSERT, PW'(CAPACITY), $urandom);
				send_item(OP_INSERT, 7'd65, $urandom);
				send_item(OP_INSERT, 7'd127, $urandom);
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
